@@ rtl/vsr_pkg.sv @@
package vsr_pkg;

	localparam int MAX_ENTRIES = 1024;
	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int VW = 64;
	localparam int SW = $clog2(VW);
	localparam int IN_W = 200;
	localparam int OUT_W = 80;

	typedef enum logic [2:0] {
		OP_PUSH  = 3'd0,
		OP_POP   = 3'd1,
		OP_PEEK  = 3'd2,
		OP_DUP   = 3'd3,
		OP_SWAP  = 3'd4,
		OP_ROLL  = 3'd5,
		OP_CLEAR = 3'd6
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_RD1, S_SWAP_B, S_SWAP_C, S_SWAP_D, S_MOD_WAIT,
		S_CP_RD, S_CP_WR, S_RT_RD, S_RT_WR, S_DONE
	} state_t;

	typedef enum logic [1:0] {RA_TOP, RA_SECOND, RA_WIN} ra_t;
	typedef enum logic [2:0] {
		WR_NONE, WR_PUSH, WR_DUP, WR_SWAP_TOP, WR_SWAP_SECOND, WR_ROLL
	} wr_t;
	typedef enum logic [1:0] {F_HOLD, F_INC, F_DEC, F_CLR} fill_op_t;

	typedef struct packed {
		logic     load;
		ra_t      rd_sel;
		wr_t      wr_sel;
		fill_op_t fill_op;
		logic     tmp_ld;
		logic     set_ok;
		logic     set_val;
		logic     mod_start;
		logic     idx_clr;
		logic     idx_inc;
		logic     src_init;
		logic     src_inc;
		logic     buf_wr;
		logic     res_ld;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       empty;
		logic       full;
		logic       ge2;
		logic       roll_ok;
		logic       mod_done;
		logic       r_zero;
		logic       idx_last;
		logic       out_busy;
	} status_t;

endpackage

@@ rtl/vsr_mod.sv @@
module vsr_mod (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [vsr_pkg::VW-1:0] dividend,
	input  logic [vsr_pkg::CW-1:0] divisor,
	output logic                 done,
	output logic [vsr_pkg::CW-1:0] rem
);
	import vsr_pkg::*;

	logic          busy_q, done_q;
	logic [SW-1:0] cnt_q;
	logic [VW-1:0] dvd_q;
	logic [CW-1:0] rem_q;
	logic [CW:0]   trial;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, dvd_q[VW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == SW'(VW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[VW-2:0], 1'b0};
			if (trial >= {1'b0, divisor})
				rem_q <= CW'(trial - {1'b0, divisor});
			else
				rem_q <= trial[CW-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule

@@ rtl/vsr_dp.sv @@
module vsr_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  vsr_pkg::cmd_t           cmd,
	output vsr_pkg::status_t        stat,
	input  logic [vsr_pkg::IN_W-1:0] in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [vsr_pkg::OUT_W-1:0] out_data
);
	import vsr_pkg::*;

	logic [VW-1:0] mem [MAX_ENTRIES];
	logic [VW-1:0] rbuf [MAX_ENTRIES];

	logic [2:0]    op_q;
	logic [VW-1:0] val_q, depth_q, count_q, rd_q, brd_q, tmp_q, value_q;
	logic [CW-1:0] fill_q, d, r, rem, base;
	logic [AW-1:0] idx_q, src_q, raddr, waddr;
	logic [VW-1:0] wdata, mag;
	logic          ok_q, mod_done, wr_en, ovalid_q;
	logic [VW-1:0] ores_val_q;
	logic          ores_ok_q, ores_empty_q, ores_full_q;
	logic [CW-1:0] ores_cnt_q;

	assign d    = depth_q[CW-1:0];
	assign base = fill_q - d;
	assign mag  = count_q[VW-1] ? (VW'(0) - count_q) : count_q;
	assign r    = (count_q[VW-1] && rem != '0) ? (d - rem) : rem;

	vsr_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.mod_start),
		.dividend (mag),
		.divisor  (d),
		.done     (mod_done),
		.rem      (rem)
	);

	always_comb begin
		case (cmd.rd_sel)
			RA_SECOND: raddr = AW'(fill_q - CW'(2));
			RA_WIN:    raddr = AW'(base + CW'(idx_q));
			default:   raddr = AW'(fill_q - CW'(1));
		endcase
		wr_en = 1'b1;
		case (cmd.wr_sel)
			WR_PUSH: begin
				waddr = fill_q[AW-1:0];
				wdata = val_q;
			end
			WR_DUP: begin
				waddr = fill_q[AW-1:0];
				wdata = rd_q;
			end
			WR_SWAP_TOP: begin
				waddr = AW'(fill_q - CW'(1));
				wdata = rd_q;
			end
			WR_SWAP_SECOND: begin
				waddr = AW'(fill_q - CW'(2));
				wdata = tmp_q;
			end
			WR_ROLL: begin
				waddr = AW'(base + CW'(idx_q));
				wdata = brd_q;
			end
			default: begin
				wr_en = 1'b0;
				waddr = '0;
				wdata = val_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[waddr] <= wdata;
		rd_q <= mem[raddr];
		if (cmd.buf_wr)
			rbuf[idx_q] <= rd_q;
		brd_q <= rbuf[src_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= in_data[2:0];
			val_q   <= in_data[66:3];
			depth_q <= in_data[130:67];
			count_q <= in_data[194:131];
		end
		if (cmd.tmp_ld)
			tmp_q <= rd_q;
		if (cmd.load)
			value_q <= '0;
		else if (cmd.set_val)
			value_q <= rd_q;
		if (cmd.idx_clr)
			idx_q <= '0;
		else if (cmd.idx_inc)
			idx_q <= idx_q + 1'b1;
		if (cmd.src_init)
			src_q <= AW'(d - r);
		else if (cmd.src_inc)
			src_q <= (CW'(src_q) + CW'(1) == d) ? '0 : src_q + 1'b1;
		if (cmd.res_ld) begin
			ores_val_q   <= value_q;
			ores_ok_q    <= ok_q;
			ores_cnt_q   <= fill_q;
			ores_empty_q <= (fill_q == '0);
			ores_full_q  <= (fill_q == CW'(MAX_ENTRIES));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			ok_q     <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			case (cmd.fill_op)
				F_INC:   fill_q <= fill_q + 1'b1;
				F_DEC:   fill_q <= fill_q - 1'b1;
				F_CLR:   fill_q <= '0;
				default: fill_q <= fill_q;
			endcase
			if (cmd.load)
				ok_q <= 1'b0;
			else if (cmd.set_ok)
				ok_q <= 1'b1;
			if (cmd.res_ld)
				ovalid_q <= 1'b1;
			else if (out_ready)
				ovalid_q <= 1'b0;
		end
	end

	assign stat.op       = op_q;
	assign stat.empty    = (fill_q == '0);
	assign stat.full     = (fill_q == CW'(MAX_ENTRIES));
	assign stat.ge2      = (fill_q >= CW'(2));
	assign stat.roll_ok  = !depth_q[VW-1] && depth_q != '0
		&& depth_q <= VW'(fill_q);
	assign stat.mod_done = mod_done;
	assign stat.r_zero   = (rem == '0);
	assign stat.idx_last = (CW'(idx_q) == d - CW'(1));
	assign stat.out_busy = ovalid_q && !out_ready;

	assign out_valid = ovalid_q;
	assign out_data  = {2'b00, ores_full_q, ores_empty_q, ores_cnt_q, ores_ok_q, ores_val_q};
endmodule

@@ rtl/vsr_ctrl.sv @@
module vsr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  vsr_pkg::status_t stat,
	output vsr_pkg::cmd_t    cmd
);
	import vsr_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.rd_sel  = RA_TOP;
		cmd.wr_sel  = WR_NONE;
		cmd.fill_op = F_HOLD;
		in_ready    = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_DONE;
				case (stat.op)
					OP_PUSH: if (!stat.full) begin
						cmd.wr_sel  = WR_PUSH;
						cmd.fill_op = F_INC;
						cmd.set_ok  = 1'b1;
					end
					OP_POP, OP_PEEK: if (!stat.empty) state_d = S_RD1;
					OP_DUP: if (!stat.empty && !stat.full) state_d = S_RD1;
					OP_SWAP: if (stat.ge2) state_d = S_SWAP_B;
					OP_ROLL: if (stat.roll_ok) begin
						cmd.mod_start = 1'b1;
						state_d       = S_MOD_WAIT;
					end
					OP_CLEAR: begin
						cmd.fill_op = F_CLR;
						cmd.set_ok  = 1'b1;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_RD1: begin
				cmd.set_ok = 1'b1;
				state_d    = S_DONE;
				case (stat.op)
					OP_POP: begin
						cmd.set_val = 1'b1;
						cmd.fill_op = F_DEC;
					end
					OP_DUP: begin
						cmd.wr_sel  = WR_DUP;
						cmd.fill_op = F_INC;
					end
					default: cmd.set_val = 1'b1;
				endcase
			end
			S_SWAP_B: begin
				cmd.tmp_ld = 1'b1;
				cmd.rd_sel = RA_SECOND;
				state_d    = S_SWAP_C;
			end
			S_SWAP_C: begin
				cmd.wr_sel = WR_SWAP_TOP;
				state_d    = S_SWAP_D;
			end
			S_SWAP_D: begin
				cmd.wr_sel = WR_SWAP_SECOND;
				cmd.set_ok = 1'b1;
				state_d    = S_DONE;
			end
			S_MOD_WAIT: if (stat.mod_done) begin
				if (stat.r_zero) begin
					cmd.set_ok = 1'b1;
					state_d    = S_DONE;
				end else begin
					cmd.idx_clr  = 1'b1;
					cmd.src_init = 1'b1;
					state_d      = S_CP_RD;
				end
			end
			S_CP_RD: begin
				cmd.rd_sel = RA_WIN;
				state_d    = S_CP_WR;
			end
			S_CP_WR: begin
				// copy the window aside, then write it back rotated
				cmd.buf_wr = 1'b1;
				if (stat.idx_last) begin
					cmd.idx_clr = 1'b1;
					state_d     = S_RT_RD;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_CP_RD;
				end
			end
			S_RT_RD: state_d = S_RT_WR;
			S_RT_WR: begin
				cmd.wr_sel = WR_ROLL;
				if (stat.idx_last) begin
					cmd.set_ok = 1'b1;
					state_d    = S_DONE;
				end else begin
					cmd.idx_inc = 1'b1;
					cmd.src_inc = 1'b1;
					state_d     = S_RT_RD;
				end
			end
			S_DONE: if (!stat.out_busy) begin
				cmd.res_ld = 1'b1;
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

@@ rtl/value_stack_with_roll.sv @@
// Bounded stack of signed 64-bit values, 1024 entries deep.
// Input channel s_*: one request per item (push, pop, peek, duplicate,
// swap, roll, clear). Output channel m_*: exactly one result per request,
// carrying the read value, a success flag, the entry count and the
// empty/full flags after the operation.
// Requests are handled one at a time; s_tready is high only while the
// controller is idle. Push, clear and failed operations complete in the
// dispatch state; pop, peek and duplicate add a read state; swap reads
// the top, reads the second entry, then writes both. Roll computes the
// bit-serial remainder of the count, then makes two passes over the
// window, each entry taking a read state and a write state because memory
// reads are registered; the passes are skipped when the count is a
// multiple of the depth.
// A new request is taken in the cycle after the result is loaded, even while
// that result still waits in the output register. If the receiver stalls
// with a result pending, the next request finishes its work and holds in
// the controller until the output register frees.
// Reset clears the entry count and the output valid; stack contents are
// not cleared and are never read before being written.
module value_stack_with_roll (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// operation[2:0], push_value[66:3], roll_depth[130:67], roll_count[194:131]
	input  logic [vsr_pkg::IN_W-1:0]     s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// read_value[63:0], success[64], entry_count[75:65], now_empty[76], now_full[77]
	output logic [vsr_pkg::OUT_W-1:0]    m_tdata
);
	import vsr_pkg::*;

	cmd_t    cmd;
	status_t stat;

	vsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	vsr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);
endmodule

@@ rtl/vsr_check.sv @@
module vsr_check (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     s_tvalid,
	input logic                     s_tready,
	input logic [vsr_pkg::IN_W-1:0]  s_tdata,
	input logic                     m_tvalid,
	input logic                     m_tready,
	input logic [vsr_pkg::OUT_W-1:0] m_tdata
);
	import vsr_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while busy");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[76] == (m_tdata[75:65] == 11'd0))
		else $error("empty flag disagrees with count");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[77] == (m_tdata[75:65] == 11'(MAX_ENTRIES)))
		else $error("full flag disagrees with count");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[64] |-> m_tdata[63:0] == 64'd0)
		else $error("failed request returned a value");
endmodule

bind value_stack_with_roll vsr_check u_vsr_check (.*);
